// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every sampled edge outside reset.
`define LFPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define LFPC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`endif

// ===== design/lfpc_pkg.sv =====
// Package for the light-frame pixel calibration block.
// Holds status codes, register indexes, fixed widths and the sideband type.
package lfpc_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INPUT = 2'd1,
		ST_BAD_FLAT  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_IN_PED   = 3'd0,
		REG_OUT_PED  = 3'd1,
		REG_SCALE    = 3'd2,
		REG_NORM     = 3'd3,
		REG_MIN_FLAT = 3'd4,
		REG_HAS_BIAS = 3'd5,
		REG_CLAMP    = 3'd6
	} reg_idx_t;

	// Signal saturates to +-(2^38 - 1); its magnitude then fits 38 bits.
	localparam int MAG_W = 38;
	localparam logic [38:0] SIG_LIMIT = 39'h3F_FFFF_FFFF;
	localparam int NORM_W = 23;
	localparam int HALF_W = 19;
	localparam int PROD_W = MAG_W + NORM_W;
	localparam int CFG_W = 24;
	// Front 3 stages, multiply 2, divide PROD_W, output 1.
	localparam int LATENCY = 3 + 2 + PROD_W + 1;

	// Per-item sideband that rides along the pipeline.
	typedef struct packed {
		status_t status;
		logic    sign;
		logic    sig_sat;
	} side_t;

endpackage

// ===== design/lfpc_front.sv =====
// Front end: validity checks, pedestal and dark subtraction, dark scaling,
// signal saturation. Three stages. Depends on lfpc_pkg.
module lfpc_front #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [SAMPLE_BITS-1:0]  light,
	input  logic signed [SAMPLE_BITS-1:0]  bias,
	input  logic signed [SAMPLE_BITS-1:0]  dark,
	input  logic signed [SAMPLE_BITS-1:0]  flat,
	input  logic                           light_ok,
	input  logic                           bias_ok,
	input  logic                           dark_ok,
	input  logic                           flat_ok,
	input  logic [22:0]                    input_pedestal,
	input  logic [23:0]                    dark_scale,
	input  logic [22:0]                    min_flat_response,
	input  logic                           dark_has_bias,
	output logic                           out_valid,
	output lfpc_pkg::side_t                out_side,
	output logic [lfpc_pkg::MAG_W-1:0]     out_mag,
	output logic [SAMPLE_BITS-2:0]         out_flat
);

	localparam int AW = ((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24) + 2;
	localparam int PRW = AW + 25;
	localparam int SW = PRW + 1;
	localparam logic [24:0] SCALE_ONE = 25'(1) << FRAC_BITS;
	localparam logic signed [PRW-1:0] RND = PRW'((64'(1) << FRAC_BITS) - 64'(1));
	localparam logic signed [SW-1:0] LIM = SW'(lfpc_pkg::SIG_LIMIT);

	logic signed [AW-1:0] light_x, bias_x, dark_x, flat_x, ped_x, min_x;
	logic scale_one, needs_bias;
	lfpc_pkg::status_t status_c;

	// Stage 1: checks and the plain subtractions
	always_comb begin
		light_x = AW'(light);
		bias_x = AW'(bias);
		dark_x = AW'(dark);
		flat_x = AW'(flat);
		ped_x = AW'($signed({1'b0, input_pedestal}));
		min_x = AW'($signed({1'b0, min_flat_response}));
		scale_one = ({1'b0, dark_scale} == SCALE_ONE);
		needs_bias = !dark_has_bias || !scale_one;
		if (!light_ok || !dark_ok || (needs_bias && !bias_ok)) begin
			status_c = lfpc_pkg::ST_BAD_INPUT;
		end else if (!flat_ok || (flat_x <= min_x)) begin
			status_c = lfpc_pkg::ST_BAD_FLAT;
		end else begin
			status_c = lfpc_pkg::ST_OK;
		end
	end

	logic                   valid_s1, valid_s2, valid_s3;
	lfpc_pkg::status_t      status_s1, status_s2;
	logic signed [AW-1:0]   base_s1, base_s2, db_s1;
	logic                   use_s1, use_s2;
	logic [SAMPLE_BITS-2:0] flat_s1, flat_s2, flat_s3;
	logic signed [PRW-1:0]  prod_s2;
	lfpc_pkg::side_t        side_s3;
	logic [lfpc_pkg::MAG_W-1:0] mag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= status_c;
		base_s1 <= light_x - ped_x - (needs_bias ? bias_x : dark_x);
		db_s1 <= dark_has_bias ? (dark_x - bias_x) : dark_x;
		use_s1 <= needs_bias;
		flat_s1 <= flat[SAMPLE_BITS-2:0];
	end

	// Stage 2: dark times scale
	always_ff @(posedge clk) begin
		status_s2 <= status_s1;
		base_s2 <= base_s1;
		use_s2 <= use_s1;
		flat_s2 <= flat_s1;
		prod_s2 <= PRW'(db_s1) * PRW'($signed({1'b0, dark_scale}));
	end

	// Stage 3: truncate toward zero, subtract, saturate, split sign
	logic signed [PRW-1:0] trunc_c;
	logic signed [SW-1:0]  sig_c, sat_c;
	logic                  sat_flag_c;
	always_comb begin
		trunc_c = $signed(prod_s2 + (prod_s2[PRW-1] ? RND : PRW'(0))) >>> FRAC_BITS;
		sig_c = SW'(base_s2) - (use_s2 ? SW'(trunc_c) : '0);
		sat_flag_c = 1'b0;
		sat_c = sig_c;
		if (sig_c > LIM) begin
			sat_c = LIM;
			sat_flag_c = 1'b1;
		end else if (sig_c < -LIM) begin
			sat_c = -LIM;
			sat_flag_c = 1'b1;
		end
		if (sat_c[SW-1]) begin
			sat_c = -sat_c;
		end
	end

	always_ff @(posedge clk) begin
		side_s3.status <= status_s2;
		side_s3.sign <= sig_c[SW-1];
		side_s3.sig_sat <= sat_flag_c;
		mag_s3 <= sat_c[lfpc_pkg::MAG_W-1:0];
		flat_s3 <= flat_s2;
	end

	assign out_valid = valid_s3;
	assign out_side = side_s3;
	assign out_mag = mag_s3;
	assign out_flat = flat_s3;

endmodule

// ===== design/lfpc_mul.sv =====
// Magnitude times flat normalization in two partial products, two stages.
// Depends on lfpc_pkg.
module lfpc_mul #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  lfpc_pkg::side_t                   in_side,
	input  logic [lfpc_pkg::MAG_W-1:0]        in_mag,
	input  logic [SAMPLE_BITS-2:0]            in_flat,
	input  logic [lfpc_pkg::NORM_W-1:0]       flat_norm,
	output logic                              out_valid,
	output lfpc_pkg::side_t                   out_side,
	output logic [lfpc_pkg::PROD_W-1:0]       out_prod,
	output logic [SAMPLE_BITS-2:0]            out_flat
);

	localparam int PPW = lfpc_pkg::HALF_W + lfpc_pkg::NORM_W;

	logic                   valid_s4, valid_s5;
	lfpc_pkg::side_t        side_s4, side_s5;
	logic [PPW-1:0]         lo_s4, hi_s4;
	logic [SAMPLE_BITS-2:0] flat_s4, flat_s5;
	logic [lfpc_pkg::PROD_W-1:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 4: low and high halves times the normalization
	always_ff @(posedge clk) begin
		side_s4 <= in_side;
		flat_s4 <= in_flat;
		lo_s4 <= PPW'(in_mag[lfpc_pkg::HALF_W-1:0]) * PPW'(flat_norm);
		hi_s4 <= PPW'(in_mag[lfpc_pkg::MAG_W-1:lfpc_pkg::HALF_W]) * PPW'(flat_norm);
	end

	// Stage 5: combine partial products
	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		flat_s5 <= flat_s4;
		prod_s5 <= (lfpc_pkg::PROD_W'(hi_s4) << lfpc_pkg::HALF_W) + lfpc_pkg::PROD_W'(lo_s4);
	end

	assign out_valid = valid_s5;
	assign out_side = side_s5;
	assign out_prod = prod_s5;
	assign out_flat = flat_s5;

endmodule

// ===== design/lfpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on lfpc_pkg.
module lfpc_div #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  lfpc_pkg::side_t               in_side,
	input  logic [lfpc_pkg::PROD_W-1:0]   in_num,
	input  logic [SAMPLE_BITS-2:0]        in_den,
	output logic                          out_valid,
	output lfpc_pkg::side_t               out_side,
	output logic [lfpc_pkg::PROD_W-1:0]   out_quot
);

	localparam int N = lfpc_pkg::PROD_W;
	localparam int DW = SAMPLE_BITS - 1;

	// Dividend bits shift out the top while quotient bits shift in below.
	logic [N:1]            valid_q;
	lfpc_pkg::side_t       side_q [1:N];
	logic [N-1:0]          num_q  [1:N];
	logic [DW-1:0]         rem_q  [1:N];
	logic [DW-1:0]         den_q  [1:N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic            v_in;
		lfpc_pkg::side_t s_in;
		logic [N-1:0]    n_in;
		logic [DW-1:0]   r_in, d_in;
		logic [DW:0]     trial;
		logic            ge;

		// First stage takes the new transfer, the others the stage before
		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign s_in = in_side;
			assign n_in = in_num;
			assign r_in = '0;
			assign d_in = in_den;
		end else begin : g_next
			assign v_in = valid_q[i];
			assign s_in = side_q[i];
			assign n_in = num_q[i];
			assign r_in = rem_q[i];
			assign d_in = den_q[i];
		end

		always_comb begin
			trial = {r_in, n_in[N-1]};
			ge = (trial >= {1'b0, d_in});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[i+1] <= 1'b0;
			end else begin
				valid_q[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			side_q[i+1] <= s_in;
			den_q[i+1] <= d_in;
			num_q[i+1] <= {n_in[N-2:0], ge};
			rem_q[i+1] <= ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);
		end
	end

	assign out_valid = valid_q[N];
	assign out_side = side_q[N];
	assign out_quot = num_q[N];

endmodule

// ===== design/light_frame_pixel_calibration_top.sv =====
// Top level of the light-frame pixel calibration block.
// Holds the register file and output stage; uses lfpc_front, lfpc_mul, lfpc_div, lfpc_pkg.
//
// Usage:
//  - Input: a pixel transfer happens at a rising edge with start high and
//    busy low. busy is always low; one pixel may enter every cycle.
//  - Output: done is high for one cycle with pixel, status, went_negative
//    and saturated. The receiver cannot stall and needs no handshake.
//  - Pipeline: the result is registered in the output stage after 3 front
//    stages, 2 multiply stages and 61 divider stages. Throughput is one
//    pixel per cycle; the 61-stage one-bit-per-stage divider makes up
//    most of the pipeline depth.
//  - Config: cfg_valid/cfg_ready write channel, cfg_ready always high;
//    cfg_index selects the register, unknown indexes are dropped. Write
//    only while no pixel is in flight.
//  - Reset: arst_n low clears all stage valid bits and loads register
//    defaults; pixels in flight are dropped.
module light_frame_pixel_calibration_top #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] light,
	input  logic signed [SAMPLE_BITS-1:0] bias,
	input  logic signed [SAMPLE_BITS-1:0] dark,
	input  logic signed [SAMPLE_BITS-1:0] flat,
	input  logic                          light_ok,
	input  logic                          bias_ok,
	input  logic                          dark_ok,
	input  logic                          flat_ok,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [lfpc_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] pixel,
	output logic [1:0]                    status,
	output logic                          went_negative,
	output logic                          saturated
);

	logic [22:0] in_ped_q, out_ped_q, norm_q, min_flat_q;
	logic [23:0] scale_q;
	logic        has_bias_q, clamp_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ped_q <= '0;
			out_ped_q <= '0;
			scale_q <= 24'd65536;
			norm_q <= 23'd65536;
			min_flat_q <= 23'd1;
			has_bias_q <= 1'b1;
			clamp_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lfpc_pkg::REG_IN_PED:   in_ped_q <= cfg_data[22:0];
				lfpc_pkg::REG_OUT_PED:  out_ped_q <= cfg_data[22:0];
				lfpc_pkg::REG_SCALE:    scale_q <= cfg_data[23:0];
				lfpc_pkg::REG_NORM:     norm_q <= cfg_data[22:0];
				lfpc_pkg::REG_MIN_FLAT: min_flat_q <= cfg_data[22:0];
				lfpc_pkg::REG_HAS_BIAS: has_bias_q <= cfg_data[0];
				lfpc_pkg::REG_CLAMP:    clamp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	logic                        f_valid, m_valid, d_valid;
	lfpc_pkg::side_t             f_side, m_side, d_side;
	logic [lfpc_pkg::MAG_W-1:0]  f_mag;
	logic [SAMPLE_BITS-2:0]      f_flat, m_flat;
	logic [lfpc_pkg::PROD_W-1:0] m_prod, d_quot;

	lfpc_front #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.light(light), .bias(bias), .dark(dark), .flat(flat),
		.light_ok(light_ok), .bias_ok(bias_ok), .dark_ok(dark_ok), .flat_ok(flat_ok),
		.input_pedestal(in_ped_q), .dark_scale(scale_q),
		.min_flat_response(min_flat_q), .dark_has_bias(has_bias_q),
		.out_valid(f_valid), .out_side(f_side), .out_mag(f_mag), .out_flat(f_flat)
	);

	lfpc_mul #(.SAMPLE_BITS(SAMPLE_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_side(f_side),
		.in_mag(f_mag), .in_flat(f_flat), .flat_norm(norm_q),
		.out_valid(m_valid), .out_side(m_side), .out_prod(m_prod), .out_flat(m_flat)
	);

	lfpc_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(m_valid), .in_side(m_side),
		.in_num(m_prod), .in_den(m_flat),
		.out_valid(d_valid), .out_side(d_side), .out_quot(d_quot)
	);

	// Output stage: sign, pedestal, clamp, saturate
	localparam logic signed [63:0] PMAX = 64'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
	localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;

	logic signed [63:0] mag_c, val_c;
	logic               neg_c, sat_c;
	always_comb begin
		mag_c = $signed({3'b000, d_quot});
		val_c = (d_side.sign ? -mag_c : mag_c) + $signed({41'd0, out_ped_q});
		neg_c = val_c[63];
		sat_c = d_side.sig_sat;
		if (neg_c && clamp_q) begin
			val_c = '0;
		end
		if (val_c > PMAX) begin
			val_c = PMAX;
			sat_c = 1'b1;
		end else if (val_c < PMIN) begin
			val_c = PMIN;
			sat_c = 1'b1;
		end
	end

	logic                          done_q, neg_q, sat_q;
	logic signed [SAMPLE_BITS-1:0] pixel_q;
	logic [1:0]                    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= d_side.status;
		if (d_side.status == lfpc_pkg::ST_OK) begin
			pixel_q <= val_c[SAMPLE_BITS-1:0];
			neg_q <= neg_c;
			sat_q <= sat_c;
		end else begin
			pixel_q <= '0;
			neg_q <= 1'b0;
			sat_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign pixel = pixel_q;
	assign status = status_q;
	assign went_negative = neg_q;
	assign saturated = sat_q;

endmodule

// ===== design/lfpc_checker.sv =====
// Port-level checker for the calibration block, bound to the top level.
// Depends on lfpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfpc_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [SAMPLE_BITS-1:0] pixel,
	input logic [1:0]                    status,
	input logic                          went_negative,
	input logic                          saturated
);

	localparam int LAT = lfpc_pkg::LATENCY;

	logic rejected, cleared;
	assign rejected = done && (status != lfpc_pkg::ST_OK);
	assign cleared = (pixel == '0) && !went_negative && !saturated;

	// Every accepted pixel comes out a fixed number of cycles later
	`LFPC_ASSERT(a_latency, (start && !busy) |-> ##LAT done, "accepted pixel not delivered")
	// No result without a matching transfer
	`LFPC_ASSERT(a_no_extra, done |-> $past(start && !busy, LAT), "result without input")
	// A rejected pixel is zero with both flags clear
	`LFPC_ASSERT(a_reject_zero, rejected |-> cleared, "rejected pixel not zero")
	// No status code beyond the invalid-flat code is produced
	`LFPC_NEVER(a_status_code, done && status > lfpc_pkg::ST_BAD_FLAT, "undefined status code")

endmodule

bind light_frame_pixel_calibration_top lfpc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lfpc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.pixel(pixel), .status(status), .went_negative(went_negative), .saturated(saturated)
);

// ===== sim/lfpc_pixel_checker.sv =====
// Checker for the light-frame pixel calibration block: tracks register writes,
// predicts each calibrated pixel and compares it with the block's output.
// Depends on lfpc_pkg.
module lfpc_pixel_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic signed [23:0]      light,
	input  logic signed [23:0]      bias,
	input  logic signed [23:0]      dark,
	input  logic signed [23:0]      flat,
	input  logic                    light_ok,
	input  logic                    bias_ok,
	input  logic                    dark_ok,
	input  logic                    flat_ok,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [lfpc_pkg::CFG_W-1:0] cfg_data,
	input  logic                    done,
	input  logic signed [23:0]      pixel,
	input  logic [1:0]              status,
	input  logic                    went_negative,
	input  logic                    saturated,
	output int                      fail_count,
	output int                      pending,
	output int                      compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [23:0] pixel;
		lfpc_pkg::status_t  status;
		logic               neg;
		logic               sat;
	} pixel_res_t;

	localparam logic [23:0] SCALE_ONE = 24'h010000;
	localparam longint SIG_MAX = (longint'(1) << 38) - 1;
	localparam longint PIX_MAX = (longint'(1) << 23) - 1;
	localparam longint PIX_MIN = -PIX_MAX - 1;

	// Shadow copy of the register file
	logic [22:0] in_ped, out_ped, norm, min_flat;
	logic [23:0] scale;
	logic        has_bias, clamp;

	pixel_res_t expected_pixels[$];

	function automatic pixel_res_t calibrate_pixel(logic signed [23:0] l, logic signed [23:0] b,
			logic signed [23:0] d, logic signed [23:0] f, logic lok, logic bok, logic dok,
			logic fok);
		longint sig, val;
		bit scale_one, need_bias;
		pixel_res_t r;
		r = '0;
		r.status = lfpc_pkg::ST_OK;
		scale_one = (scale == SCALE_ONE);
		need_bias = !has_bias || !scale_one;
		if (!lok || !dok || (need_bias && !bok)) begin
			r.status = lfpc_pkg::ST_BAD_INPUT;
			return r;
		end
		if (!fok || longint'(f) <= longint'(min_flat)) begin
			r.status = lfpc_pkg::ST_BAD_FLAT;
			return r;
		end
		sig = longint'(l) - longint'(in_ped);
		// dark correction; longint division truncates toward zero
		if (has_bias && scale_one)
			sig = sig - longint'(d);
		else if (has_bias)
			sig = sig - longint'(b) - (longint'(scale) * (longint'(d) - longint'(b))) / 65536;
		else
			sig = sig - longint'(b) - (longint'(scale) * longint'(d)) / 65536;
		if (sig > SIG_MAX) begin
			sig = SIG_MAX;
			r.sat = 1'b1;
		end
		if (sig < -SIG_MAX) begin
			sig = -SIG_MAX;
			r.sat = 1'b1;
		end
		val = (sig * longint'(norm)) / longint'(f) + longint'(out_ped);
		if (val < 0) begin
			r.neg = 1'b1;
			if (clamp)
				val = 0;
		end
		if (val > PIX_MAX) begin
			val = PIX_MAX;
			r.sat = 1'b1;
		end
		if (val < PIX_MIN) begin
			val = PIX_MIN;
			r.sat = 1'b1;
		end
		r.pixel = val[23:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Register shadow, transfer prediction and result compare
	always @(posedge clk or negedge arst_n) begin
		pixel_res_t want;
		if (!arst_n) begin
			in_ped <= '0;
			out_ped <= '0;
			scale <= SCALE_ONE;
			norm <= 23'h010000;
			min_flat <= 23'd1;
			has_bias <= 1'b1;
			clamp <= 1'b0;
			fail_count <= 0;
			compared <= 0;
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lfpc_pkg::REG_IN_PED:   in_ped <= cfg_data[22:0];
					lfpc_pkg::REG_OUT_PED:  out_ped <= cfg_data[22:0];
					lfpc_pkg::REG_SCALE:    scale <= cfg_data;
					lfpc_pkg::REG_NORM:     norm <= cfg_data[22:0];
					lfpc_pkg::REG_MIN_FLAT: min_flat <= cfg_data[22:0];
					lfpc_pkg::REG_HAS_BIAS: has_bias <= cfg_data[0];
					lfpc_pkg::REG_CLAMP:    clamp <= cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				expected_pixels.insert(expected_pixels.size(), calibrate_pixel(light,
					bias, dark, flat, light_ok, bias_ok, dark_ok, flat_ok));
			if (done) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected result, pixel", pixel, 0);
				end else begin
					want = expected_pixels.pop_front();
					compared <= compared + 1;
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (pixel !== want.pixel)
						report_mismatch("pixel", pixel, want.pixel);
					if (went_negative !== want.neg)
						report_mismatch("went_negative", went_negative, want.neg);
					if (saturated !== want.sat)
						report_mismatch("saturated", saturated, want.sat);
				end
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== sim/tb_light_frame_pixel_calibration_top.sv =====
// Testbench top for light_frame_pixel_calibration_top: clock, reset, register
// settings and pixel stimulus. Checking lives in lfpc_pixel_checker; uses lfpc_pkg.
module tb_light_frame_pixel_calibration_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNKNOWN = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [22:0] MAX23 = 23'h7FFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [23:0] light = '0, bias = '0, dark = '0, flat = '0;
	logic light_ok = 1'b0, bias_ok = 1'b0, dark_ok = 1'b0, flat_ok = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [lfpc_pkg::CFG_W-1:0] cfg_data = '0;
	logic done;
	logic signed [23:0] pixel;
	logic [1:0] status;
	logic went_negative, saturated;
	int fail_count, pending, compared;

	int cycles = 0;
	int sent = 0;
	int phases = 0;
	logic [22:0] cur_min_flat = 23'd1;
	bit allow_idle = 1'b1;

	light_frame_pixel_calibration_top i_dut (.*);
	lfpc_pixel_checker i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Writes every register, plus an unknown index that must be dropped
	task automatic apply_settings(logic [22:0] ip, logic [22:0] op, logic [23:0] sc,
			logic [22:0] nm, logic [22:0] mf, logic hb, logic cl);
		logic [2:0] idx[8];
		logic [23:0] val[8];
		idx = '{lfpc_pkg::REG_IN_PED, lfpc_pkg::REG_OUT_PED, lfpc_pkg::REG_SCALE,
			lfpc_pkg::REG_NORM, lfpc_pkg::REG_MIN_FLAT, lfpc_pkg::REG_HAS_BIAS,
			lfpc_pkg::REG_CLAMP, REG_UNKNOWN};
		val = '{{1'b0, ip}, {1'b0, op}, sc, {1'b0, nm}, {1'b0, mf},
			{23'($urandom), hb}, {23'($urandom), cl}, 24'($urandom)};
		for (int i = 0; i < 8; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_min_flat = mf;
		phases++;
	endtask

	// Stop sending, then wait until every pixel in flight is out
	task automatic drain;
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (lfpc_pkg::LATENCY + 4) @(posedge clk);
	endtask

	// One pixel transfer, then possibly an idle burst
	task automatic send_pixel(logic [23:0] l, logic [23:0] b, logic [23:0] d, logic [23:0] f,
			logic [3:0] oks);
		light <= l;
		bias <= b;
		dark <= d;
		flat <= f;
		{light_ok, bias_ok, dark_ok, flat_ok} <= oks;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 4000)) - 2000);
			2: return 24'($urandom_range(0, 24'h7FFFFF));
			default: return {{4{$urandom_range(0, 1) == 1}}, 20'($urandom)};
		endcase
	endfunction

	function automatic logic [23:0] pick_flat();
		int unsigned lo;
		lo = cur_min_flat + 1;
		if (cur_min_flat == MAX23 || $urandom_range(0, 9) == 0)
			return 24'($urandom);
		if ($urandom_range(0, 2) == 0)
			return 24'($urandom_range(lo, (lo + 256 > 24'h7FFFFF) ? 24'h7FFFFF : lo + 256));
		return 24'($urandom_range(lo, 24'h7FFFFF));
	endfunction

	task automatic random_pixels(int n);
		logic [3:0] oks;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 4; k++)
				oks[k] = ($urandom_range(0, 19) != 0);
			send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_flat(), oks);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed set at reset settings: dark includes bias, unit scale
		send_pixel(24'h000000, 24'h000000, 24'h000000, 24'h000002, 4'b1111);
		send_pixel(24'h7FFFFF, 24'h000000, 24'h800000, 24'h000002, 4'b1111);
		send_pixel(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000002, 4'b1111);
		send_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'b1111);
		send_pixel(24'h800000, 24'h800000, 24'h800000, 24'h010000, 4'b1111);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h010000, 4'b0111);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h010000, 4'b1011);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h010000, 4'b1101);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h010000, 4'b1110);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h000001, 4'b1111);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h000000, 4'b1111);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'hFFFFFF, 4'b1111);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h800000, 4'b1111);
		send_pixel(24'h000010, 24'h000000, 24'h000020, 24'h010000, 4'b1111);
		send_pixel(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 4'b0000);
		drain();

		// Bias-free dark at unit scale: bias now needed
		apply_settings(23'd0, 23'd0, 24'h010000, 23'h010000, 23'd1, 1'b0, 1'b1);
		send_pixel(24'h123456, 24'h000100, 24'h000100, 24'h010000, 4'b1011);
		send_pixel(24'h000010, 24'h000000, 24'h000020, 24'h010000, 4'b1111);
		send_pixel(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h000002, 4'b1111);
		random_pixels(60);
		drain();

		// Upper extremes: every flat is rejected
		apply_settings(MAX23, MAX23, 24'hFFFFFF, MAX23, MAX23, 1'b1, 1'b1);
		random_pixels(20);
		drain();

		// Lower extremes, then out-of-range zeros for norm and minimum flat
		apply_settings(23'd0, 23'd0, 24'h000000, 23'd1, 23'd1, 1'b0, 1'b0);
		random_pixels(60);
		drain();
		apply_settings(23'd0, 23'd0, 24'h000000, 23'd0, 23'd0, 1'b1, 1'b0);
		random_pixels(40);
		drain();

		// Large scale and gain with small flats to push saturation
		apply_settings(23'd0, MAX23, 24'hFFFFFF, MAX23, 23'd1, 1'b1, 1'b0);
		random_pixels(60);
		drain();

		// Random settings
		for (int p = 0; p < 7; p++) begin
			apply_settings(23'($urandom), 23'($urandom),
				($urandom_range(0, 2) == 0) ? 24'h010000 : 24'($urandom),
				23'($urandom_range(1, 24'h7FFFFF)),
				($urandom_range(0, 1) == 0) ? 23'($urandom_range(1, 255)) :
					23'($urandom_range(1, 24'h7FFFFF)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (p == 6)
				allow_idle = 1'b0;
			random_pixels(110);
			drain();
		end

		$display("Sent %0d pixels across %0d register settings plus reset defaults;",
			sent, phases);
		$display("%0d results compared in %0d cycles.", compared, cycles);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
